/* rtl/lkv_pkg.sv */
// ----------------------------------------------------------------------------
// LRU key/value cache package
// Widths, reset values, command codes, state encoding and the per-cell
// control word shared by the cache top level and its cells.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lkv_pkg;

  localparam int KeyW        = 32;
  localparam int ValW        = 32;
  localparam int CapW        = 5;
  localparam int ENTRIES_DEF = 16;

  localparam logic [CapW-1:0] CAP_RESET = 5'd16;

  typedef enum logic {
    CMD_GET = 1'b0,
    CMD_PUT = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MATCH,
    S_APPLY
  } state_e;

  typedef struct packed {
    logic capture;
    logic shift_all;
    logic promote;
  } cell_ctrl_t;

endpackage

/* rtl/lkv_cell.sv */
// ----------------------------------------------------------------------------
// LRU cache cell
// One slot of the recency-ordered list. It compares its key against the
// broadcast key, passes the first-hit flag and the hit value along the row,
// and loads its neighbor's entry when the list shifts through it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lkv_cell (
  input  logic                      clk_i,
  input  lkv_pkg::cell_ctrl_t       ctrl_i,
  input  logic                      valid_i,
  input  logic [lkv_pkg::KeyW-1:0]  cmp_key_i,
  input  logic [lkv_pkg::KeyW-1:0]  nb_key_i,
  input  logic [lkv_pkg::ValW-1:0]  nb_value_i,
  input  logic                      seen_i,
  input  logic [lkv_pkg::ValW-1:0]  sel_value_i,
  output logic [lkv_pkg::KeyW-1:0]  key_o,
  output logic [lkv_pkg::ValW-1:0]  value_o,
  output logic                      match_o,
  output logic                      seen_o,
  output logic [lkv_pkg::ValW-1:0]  sel_value_o
);

  logic [lkv_pkg::KeyW-1:0] key_q;
  logic [lkv_pkg::ValW-1:0] value_q;
  logic                     match_q;
  logic                     first_hit;
  logic                     load;

  assign first_hit   = match_q & ~seen_i;
  assign seen_o      = seen_i | match_q;
  assign sel_value_o = first_hit ? (sel_value_i | value_q) : sel_value_i;
  assign load        = ctrl_i.shift_all | (ctrl_i.promote & ~seen_i);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.capture) begin
      match_q <= valid_i && (key_q == cmp_key_i);
    end
    if (load) begin
      key_q   <= nb_key_i;
      value_q <= nb_value_i;
    end
  end

  assign key_o   = key_q;
  assign value_o = value_q;
  assign match_o = match_q;

endmodule

/* rtl/lru_key_value_cache.sv */
// ----------------------------------------------------------------------------
// LRU key/value cache
// Fully associative key/value store kept as a row of cells ordered from
// most to least recently used, with least-recently-used eviction.
// An accepted command passes the compare state (S_MATCH) and the update
// state (S_APPLY); its result strobe and result word come from registers.
// A new command is taken only in the idle state, after the compare and the
// shift through the cell row; busy is high during both.
// Reset empties the list and sets the capacity to sixteen; results cannot be
// stalled by the receiver.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lru_key_value_cache #(
  parameter int ENTRIES = lkv_pkg::ENTRIES_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start,
  output logic                             busy,
  input  logic                             command_i,
  input  logic signed [lkv_pkg::KeyW-1:0]  key_i,
  input  logic signed [lkv_pkg::ValW-1:0]  value_i,
  output logic                             strobe_o,
  output logic                             found_o,
  output logic signed [lkv_pkg::ValW-1:0]  read_value_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [lkv_pkg::CapW-1:0]         cfg_data_i
);

  localparam int OccW = $clog2(ENTRIES + 1);
  localparam int CmpW = (OccW > lkv_pkg::CapW) ? OccW : lkv_pkg::CapW;

  lkv_pkg::state_e state_q, state_d;

  lkv_pkg::cmd_e              cmd_q;
  logic [lkv_pkg::KeyW-1:0]   key_q;
  logic [lkv_pkg::ValW-1:0]   val_q;
  logic [OccW-1:0]            occ_q, occ_d;
  logic [lkv_pkg::CapW-1:0]   cap_q;
  logic                       strobe_q;
  logic                       found_q;
  logic [lkv_pkg::ValW-1:0]   rdval_q;

  logic                       accept;
  lkv_pkg::cell_ctrl_t        ctrl;
  logic                       any_hit;
  logic [lkv_pkg::ValW-1:0]   hit_value;
  logic [lkv_pkg::ValW-1:0]   front_value;

  logic [lkv_pkg::KeyW-1:0]   cell_key   [ENTRIES];
  logic [lkv_pkg::ValW-1:0]   cell_val   [ENTRIES];
  logic [ENTRIES-1:0]         cell_valid;
  logic [ENTRIES-1:0]         cell_match;
  logic [ENTRIES:0]           seen;
  logic [lkv_pkg::ValW-1:0]   sel_val    [ENTRIES+1];

  logic [OccW-1:0]            keep;
  logic [CmpW-1:0]            ins_occ;
  logic [CmpW-1:0]            cap_ext;
  logic [CmpW-1:0]            cap_eff;

  assign accept      = start && !busy;
  assign cfg_ready_o = !busy;

  always_comb begin
    state_d = state_q;
    busy    = 1'b1;
    unique case (state_q)
      lkv_pkg::S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          state_d = lkv_pkg::S_MATCH;
        end
      end
      lkv_pkg::S_MATCH: state_d = lkv_pkg::S_APPLY;
      lkv_pkg::S_APPLY: state_d = lkv_pkg::S_IDLE;
      default:          state_d = lkv_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lkv_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Cell row.
  assign seen[0]    = 1'b0;
  assign sel_val[0] = '0;
  assign any_hit    = seen[ENTRIES];
  assign hit_value  = sel_val[ENTRIES];

  assign ctrl.capture   = (state_q == lkv_pkg::S_MATCH);
  assign ctrl.shift_all = (state_q == lkv_pkg::S_APPLY) && (cmd_q == lkv_pkg::CMD_PUT)
                          && !any_hit;
  assign ctrl.promote   = (state_q == lkv_pkg::S_APPLY) && any_hit;

  assign front_value = (cmd_q == lkv_pkg::CMD_PUT) ? val_q : hit_value;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    logic [lkv_pkg::KeyW-1:0] nb_key;
    logic [lkv_pkg::ValW-1:0] nb_val;

    assign cell_valid[i] = (OccW'(i) < occ_q);

    if (i == 0) begin : g_front
      assign nb_key = key_q;
      assign nb_val = front_value;
    end else begin : g_link
      assign nb_key = cell_key[i-1];
      assign nb_val = cell_val[i-1];
    end

    lkv_cell u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .valid_i     (cell_valid[i]),
      .cmp_key_i   (key_q),
      .nb_key_i    (nb_key),
      .nb_value_i  (nb_val),
      .seen_i      (seen[i]),
      .sel_value_i (sel_val[i]),
      .key_o       (cell_key[i]),
      .value_o     (cell_val[i]),
      .match_o     (cell_match[i]),
      .seen_o      (seen[i+1]),
      .sel_value_o (sel_val[i+1])
    );
  end

  // Occupancy after inserting a new key at the front.
  assign keep    = (occ_q < OccW'(ENTRIES)) ? occ_q : OccW'(ENTRIES - 1);
  assign ins_occ = CmpW'(keep) + CmpW'(1);
  assign cap_ext = CmpW'(cap_q);
  assign cap_eff = (cap_ext > CmpW'(ENTRIES)) ? CmpW'(ENTRIES) : cap_ext;

  always_comb begin
    occ_d = occ_q;
    if (ctrl.shift_all) begin
      occ_d = (ins_occ > cap_eff) ? cap_eff[OccW-1:0] : ins_occ[OccW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q    <= '0;
      cap_q    <= lkv_pkg::CAP_RESET;
      strobe_q <= 1'b0;
    end else begin
      occ_q    <= occ_d;
      strobe_q <= (state_q == lkv_pkg::S_APPLY);
      if (cfg_valid_i && cfg_ready_o) begin
        cap_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= lkv_pkg::cmd_e'(command_i);
      key_q <= key_i;
      val_q <= value_i;
    end
    if (state_q == lkv_pkg::S_APPLY) begin
      found_q <= any_hit;
      if (cmd_q == lkv_pkg::CMD_PUT) begin
        rdval_q <= '0;
      end else if (any_hit) begin
        rdval_q <= hit_value;
      end else begin
        rdval_q <= '1;
      end
    end
  end

  assign strobe_o     = strobe_q;
  assign found_o      = found_q;
  assign read_value_o = rdval_q;

  // At most one valid slot can hold the looked-up key.
  a_single_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == lkv_pkg::S_APPLY) |-> $onehot0(cell_match))
    else $error("more than one cell matched the key");

  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= OccW'(ENTRIES))
    else $error("occupancy exceeds the number of cells");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == lkv_pkg::S_APPLY) |=> (strobe_o && !busy))
    else $error("result word missing after the update cycle");

  a_occ_on_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.promote |=> $stable(occ_q))
    else $error("occupancy changed on a hit");

  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (busy && !strobe_o))
    else $error("command accepted without entering the compare cycle");

endmodule

/* tb/tb_lru_key_value_cache.sv */
// ----------------------------------------------------------------------------
// LRU key/value cache testbench
// Drives get and put commands through the start/busy handshake and checks
// every result word against a recency-ordered slot list kept in the bench.
// Directed tests cover field extremes, eviction order, a capacity lowered
// below the occupancy and a capacity of zero. Random phases then run with
// several capacity settings and sender idle rates over a small key pool.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_lru_key_value_cache;

  localparam int SLOTS       = lkv_pkg::ENTRIES_DEF;
  localparam int POOL_SIZE   = 20;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_LIMIT = 100;

  typedef struct {
    logic                            found;
    logic signed [lkv_pkg::ValW-1:0] read_value;
  } cache_reply_t;

  logic                            clk_i = 1'b0;
  logic                            rst_ni;
  logic                            start;
  logic                            busy;
  logic                            command_i;
  logic signed [lkv_pkg::KeyW-1:0] key_i;
  logic signed [lkv_pkg::ValW-1:0] value_i;
  logic                            strobe_o;
  logic                            found_o;
  logic signed [lkv_pkg::ValW-1:0] read_value_o;
  logic                            cfg_valid_i;
  logic                            cfg_ready_o;
  logic [lkv_pkg::CapW-1:0]        cfg_data_i;

  logic [lkv_pkg::KeyW-1:0] cache_keys [SLOTS];
  logic [lkv_pkg::ValW-1:0] cache_vals [SLOTS];
  int                       cache_count;
  logic [lkv_pkg::CapW-1:0] capacity_reg;

  cache_reply_t             pending_replies [$];
  cache_reply_t             oldest_reply;
  logic [lkv_pkg::KeyW-1:0] key_pool [POOL_SIZE];
  int                       fail_count  = 0;
  int                       cycle_count = 0;

  lru_key_value_cache #(
    .ENTRIES (SLOTS)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .command_i    (command_i),
    .key_i        (key_i),
    .value_i      (value_i),
    .strobe_o     (strobe_o),
    .found_o      (found_o),
    .read_value_o (read_value_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  function automatic void move_to_front(int idx);
    logic [lkv_pkg::KeyW-1:0] k;
    logic [lkv_pkg::ValW-1:0] v;
    k = cache_keys[idx];
    v = cache_vals[idx];
    for (int i = idx; i > 0; i--) begin
      cache_keys[i] = cache_keys[i-1];
      cache_vals[i] = cache_vals[i-1];
    end
    cache_keys[0] = k;
    cache_vals[0] = v;
  endfunction

  function automatic void insert_front(logic [lkv_pkg::KeyW-1:0] k,
                                       logic [lkv_pkg::ValW-1:0] v);
    int keep;
    int limit;
    keep  = (cache_count < SLOTS) ? cache_count : SLOTS - 1;
    limit = (capacity_reg > SLOTS) ? SLOTS : int'(capacity_reg);
    for (int i = keep; i > 0; i--) begin
      cache_keys[i] = cache_keys[i-1];
      cache_vals[i] = cache_vals[i-1];
    end
    cache_keys[0] = k;
    cache_vals[0] = v;
    cache_count   = keep + 1;
    if (cache_count > limit) begin
      cache_count = limit;
    end
  endfunction

  function automatic cache_reply_t predict_reply(lkv_pkg::cmd_e cmd,
                                                 logic [lkv_pkg::KeyW-1:0] k,
                                                 logic [lkv_pkg::ValW-1:0] v);
    int           hit_at;
    cache_reply_t r;
    hit_at = -1;
    for (int i = 0; i < cache_count; i++) begin
      if (hit_at < 0 && cache_keys[i] == k) begin
        hit_at = i;
      end
    end
    r.found = (hit_at >= 0);
    if (cmd == lkv_pkg::CMD_GET) begin
      if (hit_at >= 0) begin
        r.read_value = cache_vals[hit_at];
        move_to_front(hit_at);
      end else begin
        r.read_value = -1;
      end
    end else begin
      r.read_value = '0;
      if (hit_at >= 0) begin
        cache_vals[hit_at] = v;
        move_to_front(hit_at);
      end else begin
        insert_front(k, v);
      end
    end
    return r;
  endfunction

  task automatic report_failure(string msg);
    fail_count++;
    if (fail_count <= 10) begin
      $display("%s", msg);
    end
  endtask

  task automatic issue_command(lkv_pkg::cmd_e cmd, logic [lkv_pkg::KeyW-1:0] k,
                               logic [lkv_pkg::ValW-1:0] v);
    @(negedge clk_i);
    start     = 1'b1;
    command_i = cmd;
    key_i     = k;
    value_i   = v;
    do @(posedge clk_i); while (busy);
    pending_replies.push_back(predict_reply(cmd, k, v));
  endtask

  task automatic write_capacity(logic [lkv_pkg::CapW-1:0] cap);
    @(negedge clk_i);
    start = 1'b0;
    while (pending_replies.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_data_i  = cap;
    do @(posedge clk_i); while (!cfg_ready_o);
    capacity_reg = cap;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && strobe_o) begin
      if (pending_replies.size() == 0) begin
        report_failure($sformatf("unexpected result word: found %0b read_value %0d",
                                 found_o, read_value_o));
      end else begin
        oldest_reply = pending_replies.pop_front();
        if (found_o !== oldest_reply.found ||
            read_value_o !== oldest_reply.read_value) begin
          report_failure($sformatf(
            "result mismatch: found exp %0b got %0b, read_value exp %0d got %0d",
            oldest_reply.found, found_o, oldest_reply.read_value, read_value_o));
        end
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  task automatic test_field_extremes();
    issue_command(lkv_pkg::CMD_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
    issue_command(lkv_pkg::CMD_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
    issue_command(lkv_pkg::CMD_PUT, 32'h0000_0000, 32'hFFFF_FFFF);
    issue_command(lkv_pkg::CMD_PUT, 32'hFFFF_FFFF, 32'h0000_0000);
    issue_command(lkv_pkg::CMD_GET, 32'h8000_0000, 32'hFFFF_FFFF);
    issue_command(lkv_pkg::CMD_GET, 32'h7FFF_FFFF, 32'h0000_0000);
    issue_command(lkv_pkg::CMD_GET, 32'h0000_0000, 32'h5555_AAAA);
    issue_command(lkv_pkg::CMD_GET, 32'h0000_3039, 32'hAAAA_5555);
    issue_command(lkv_pkg::CMD_PUT, 32'h7FFF_FFFF, 32'h0000_0001);
    issue_command(lkv_pkg::CMD_GET, 32'h7FFF_FFFF, 32'h0000_0000);
  endtask

  // Four entries are held, so the new capacity only takes effect on the
  // next insertion of a new key.
  task automatic test_lru_eviction();
    write_capacity(5'd2);
    issue_command(lkv_pkg::CMD_PUT, 32'd100, 32'd1);
    issue_command(lkv_pkg::CMD_GET, 32'h0000_0000, 32'd0);
    issue_command(lkv_pkg::CMD_PUT, 32'd200, 32'd2);
    issue_command(lkv_pkg::CMD_GET, 32'd100, 32'd0);
    issue_command(lkv_pkg::CMD_PUT, 32'd300, 32'd3);
    issue_command(lkv_pkg::CMD_GET, 32'd200, 32'd0);
  endtask

  task automatic test_capacity_shrink();
    write_capacity(5'd4);
    issue_command(lkv_pkg::CMD_PUT, 32'd1, 32'd11);
    issue_command(lkv_pkg::CMD_PUT, 32'd2, 32'd22);
    issue_command(lkv_pkg::CMD_PUT, 32'd3, 32'd33);
    issue_command(lkv_pkg::CMD_PUT, 32'd4, 32'd44);
    write_capacity(5'd1);
    issue_command(lkv_pkg::CMD_GET, 32'd1, 32'd0);
    issue_command(lkv_pkg::CMD_PUT, 32'd5, 32'd55);
    issue_command(lkv_pkg::CMD_GET, 32'd2, 32'd0);
  endtask

  task automatic test_capacity_zero();
    write_capacity(5'd0);
    issue_command(lkv_pkg::CMD_PUT, 32'd5, 32'hDEAD_BEEF);
    issue_command(lkv_pkg::CMD_GET, 32'd5, 32'd0);
    issue_command(lkv_pkg::CMD_PUT, 32'd6, 32'd66);
    issue_command(lkv_pkg::CMD_GET, 32'd6, 32'd0);
  endtask

  task automatic test_random_traffic(logic [lkv_pkg::CapW-1:0] cap, int idle_pct,
                                     int count);
    int                       span;
    logic [lkv_pkg::KeyW-1:0] k;
    write_capacity(cap);
    span = ((cap > SLOTS) ? SLOTS : int'(cap)) + 3;
    if (span > POOL_SIZE) begin
      span = POOL_SIZE;
    end
    for (int n = 0; n < count; n++) begin
      while ($urandom_range(99) < idle_pct) begin
        @(negedge clk_i);
        start = 1'b0;
      end
      if ($urandom_range(19) == 0) begin
        key_pool[$urandom_range(POOL_SIZE-1)] = $urandom;
      end
      if ($urandom_range(9) == 0) begin
        k = $urandom;
      end else begin
        k = key_pool[$urandom_range(span-1)];
      end
      issue_command(lkv_pkg::cmd_e'($urandom_range(1)), k, $urandom);
    end
  endtask

  initial begin
    rst_ni       = 1'b0;
    start        = 1'b0;
    command_i    = lkv_pkg::CMD_GET;
    key_i        = '0;
    value_i      = '0;
    cfg_valid_i  = 1'b0;
    cfg_data_i   = '0;
    cache_count  = 0;
    capacity_reg = lkv_pkg::CAP_RESET;
    for (int i = 0; i < SLOTS; i++) begin
      cache_keys[i] = '0;
      cache_vals[i] = '0;
    end
    for (int i = 0; i < POOL_SIZE; i++) begin
      key_pool[i] = $urandom;
    end
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_field_extremes();
    test_lru_eviction();
    test_capacity_shrink();
    test_capacity_zero();
    test_random_traffic(5'd16, 0, 260);
    test_random_traffic(5'd31, 55, 260);
    test_random_traffic(5'd1, 0, 260);
    test_random_traffic(5'd4, 29, 260);
    test_random_traffic(5'd0, 55, 260);
    test_random_traffic(5'd8, 29, 260);
    test_random_traffic(5'd2, 0, 260);

    @(negedge clk_i);
    start = 1'b0;
    for (int i = 0; i < DRAIN_LIMIT && pending_replies.size() != 0; i++) begin
      @(posedge clk_i);
    end
    repeat (6) @(posedge clk_i);
    while (pending_replies.size() != 0) begin
      oldest_reply = pending_replies.pop_front();
      report_failure($sformatf("missing result word: found %0b read_value %0d",
                               oldest_reply.found, oldest_reply.read_value));
    end
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
